// ===== rtl/sha256_stream_hasher_macros.svh =====
// Assertion macros for the SHA-256 stream hasher checker.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== rtl/sha_pkg.sv =====
// Package with SHA-256 constants, types and round functions.
package sha_pkg;
    localparam int BLOCK_BYTES = 64;
    localparam int LEN_OFFSET = 56;
    localparam int ROUNDS = 64;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_EMIT
    } state_t;

    // Controller command bundle to the datapath.
    typedef struct packed {
        logic write_byte;   // store incoming byte at fill pointer
        logic write_pad;    // store padding byte at fill pointer
        logic load_len;     // put length into last eight bytes
        logic comp_start;   // load working vars and clear round counter
        logic comp_round;   // execute one round
        logic comp_finish;  // add working vars into chain
        logic clear;        // return to initial state
    } cmd_t;

    // Datapath status bundle to the controller.
    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
    } status_t;

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] r;
        unique case (i)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[t];
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage

// ===== rtl/sha_if.sv =====
// Valid/ready stream interfaces for input bytes and digest words.
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_of_message;
    modport source (output valid, data_byte, byte_present, last_of_message, input ready);
    modport sink (input valid, data_byte, byte_present, last_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/sha256_stream_hasher.sv =====
// SHA-256 stream hasher: one byte per input word, eight digest words out.
// A byte that does not fill the block and is not last leaves the hasher ready.
// A full block is compressed in the single shared round unit.
// A final word pads one byte a cycle then compresses once or twice,
// and the digest follows, one word per cycle while the sink is ready.
// Reset (rst_n low, asynchronous) restores the initial hash and clears counts.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    sha_in_if.sink  in_ch,
    sha_out_if.source out_ch
);
    cmd_t       cmd;
    status_t    status;
    logic [2:0] idx;

    sha_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_present (in_ch.byte_present),
        .in_last    (in_ch.last_of_message),
        .in_ready   (in_ch.ready),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_index  (idx),
        .status     (status),
        .cmd        (cmd)
    );

    sha_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (in_ch.data_byte),
        .out_index   (idx),
        .cmd         (cmd),
        .status      (status),
        .digest_word (out_ch.digest_word)
    );

    assign out_ch.word_index = idx;
    assign out_ch.last_word = (idx == 3'd7);
endmodule

// ===== rtl/sha_ctrl.sv =====
// Controller state machine sequencing fill, padding, rounds and emission.
module sha_ctrl
    import sha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_present,
    input  logic       in_last,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] out_index,
    input  status_t    status,
    output cmd_t       cmd
);
    state_t     state_reg, state_next;
    logic       fin_reg, fin_next;       // compression belongs to final block
    logic       started_reg, started_next; // round loop already loaded
    logic       pad_pending_reg, pad_pending_next; // padding owed after a full block
    logic [2:0] idx_reg, idx_next;
    logic       accept;
    logic       full_after;

    assign accept = in_valid && in_ready;
    assign full_after = in_present && (status.fill == 6'(BLOCK_BYTES - 1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        fin_next = fin_reg;
        started_next = started_reg;
        idx_next = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (full_after)
                    begin
                        state_next = ST_COMP;
                        fin_next = 1'b0;
                        started_next = 1'b0;
                    end
                    else if (in_last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                // Writes 0x80 then zeros; goes to compression when block closes.
                if (status.fill == 6'(BLOCK_BYTES - 1))
                begin
                    state_next = ST_COMP;
                    fin_next = 1'b0;
                    started_next = 1'b0;
                end
                else if (status.fill == 6'(LEN_OFFSET - 1))
                begin
                    state_next = ST_COMP;
                    fin_next = 1'b1;
                    started_next = 1'b0;
                end
            end
            ST_COMP:
            begin
                if (!started_reg)
                    started_next = 1'b1;
                else if (status.round_last)
                begin
                    started_next = 1'b0;
                    if (fin_reg)
                    begin
                        state_next = ST_EMIT;
                        idx_next = '0;
                    end
                    else if (pad_pending_reg)
                        state_next = ST_PAD;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Tracks whether padding is still owed after a data-full compression.
    always_comb
    begin
        pad_pending_next = pad_pending_reg;
        if (state_reg == ST_IDLE && accept && full_after)
            pad_pending_next = in_last;
        else if (state_reg == ST_PAD)
            pad_pending_next = 1'b1;
        else if (state_reg == ST_EMIT)
            pad_pending_next = 1'b0;
    end

    // Outputs.
    always_comb
    begin
        cmd = '0;
        in_ready = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_EMIT);
        unique case (state_reg)
            ST_IDLE:    cmd.write_byte = accept && in_present;
            ST_PAD:
            begin
                cmd.write_pad = 1'b1;
                cmd.load_len = (status.fill == 6'(LEN_OFFSET - 1));
            end
            ST_COMP:
            begin
                cmd.comp_start = !started_reg;
                cmd.comp_round = started_reg;
                cmd.comp_finish = started_reg && status.round_last;
            end
            ST_EMIT:    cmd.clear = out_ready && (idx_reg == 3'd7);
            default:    cmd = '0;
        endcase
    end

    assign out_index = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fin_reg <= 1'b0;
            started_reg <= 1'b0;
            idx_reg <= '0;
            pad_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg <= fin_next;
            started_reg <= started_next;
            idx_reg <= idx_next;
            pad_pending_reg <= pad_pending_next;
        end
    end
endmodule

// ===== rtl/sha_dp.sv =====
// Datapath: block buffer in the schedule window, round unit and chain words.
module sha_dp
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  in_byte,
    input  logic [2:0]  out_index,
    input  cmd_t        cmd,
    output status_t     status,
    output logic [31:0] digest_word
);
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  t_reg;
    logic        first_pad_reg;

    // Byte written this cycle, if any.
    logic        wr;
    logic [7:0]  wr_byte;
    always_comb
    begin
        wr = cmd.write_byte || cmd.write_pad;
        wr_byte = cmd.write_byte ? in_byte : (first_pad_reg ? PAD_BYTE : 8'h00);
    end

    // Round function and schedule step.
    logic [31:0] s1, ch, t1, s0, mj, t2, wn, w1, w14;
    always_comb
    begin
        s1 = ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + s1 + ch + round_k(t_reg) + w_reg[0];
        s0 = ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = s0 + mj;
        w1 = w_reg[1];
        w14 = w_reg[14];
        wn = w_reg[0] + (ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3)) + w_reg[9]
           + (ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10));
    end

    // Working variables and schedule window. The window also collects the
    // block: bytes land big-endian in word fill/4, and the length lands in
    // the last two words together with the last pad byte.
    always_ff @(posedge clk)
    begin
        if (cmd.comp_start)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
        else if (cmd.comp_round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= wn;
        end
        else
        begin
            if (wr)
                w_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= wr_byte;
            if (cmd.load_len)
            begin
                w_reg[14] <= bits_reg[63:32];
                w_reg[15] <= bits_reg[31:0];
            end
        end
    end

    // Control state of the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            bits_reg <= '0;
            t_reg <= '0;
            first_pad_reg <= 1'b1;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= init_hash(3'(i));
        end
        else
        begin
            if (cmd.load_len)
                fill_reg <= '0;
            else if (wr)
                fill_reg <= fill_reg + 6'd1;
            if (cmd.write_byte)
                bits_reg <= bits_reg + 64'd8;
            if (cmd.write_pad)
                first_pad_reg <= 1'b0;
            if (cmd.comp_start)
                t_reg <= '0;
            else if (cmd.comp_round)
                t_reg <= t_reg + 6'd1;
            if (cmd.comp_finish)
            begin
                h_reg[0] <= h_reg[0] + t1 + t2;
                h_reg[1] <= h_reg[1] + v_reg[0];
                h_reg[2] <= h_reg[2] + v_reg[1];
                h_reg[3] <= h_reg[3] + v_reg[2];
                h_reg[4] <= h_reg[4] + v_reg[3] + t1;
                h_reg[5] <= h_reg[5] + v_reg[4];
                h_reg[6] <= h_reg[6] + v_reg[5];
                h_reg[7] <= h_reg[7] + v_reg[6];
            end
            if (cmd.clear)
            begin
                fill_reg <= '0;
                bits_reg <= '0;
                first_pad_reg <= 1'b1;
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= init_hash(3'(i));
            end
        end
    end

    assign status.fill = fill_reg;
    assign status.round_last = (t_reg == 6'(ROUNDS - 1));
    assign digest_word = h_reg[out_index];
endmodule

// ===== rtl/sha_checker.sv =====
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
`include "sha256_stream_hasher_macros.svh"
module sha_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  word_index,
    input logic        last_word
);
    // Input is never taken while a digest is being shown.
    `SHA_ASSERT_IMP(a_excl, clk, rst_n, out_valid, !in_ready)
    // The last flag marks exactly word seven.
    `SHA_ASSERT_IMP(a_last, clk, rst_n, out_valid, last_word == (word_index == 3'd7))
    // After a taken word that is not last, the next word follows in order.
    `SHA_ASSERT_NXT(a_next, clk, rst_n, out_valid && out_ready && !last_word,
        out_valid && word_index == $past(word_index) + 3'd1)
endmodule

bind sha256_stream_hasher sha_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .word_index (out_ch.word_index),
    .last_word  (out_ch.last_word)
);
